### rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants of the sorted table search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int CFG_W       = 7;
	localparam int POS_W       = 6;
	localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_DUPLICATE = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	// table memory request from the sequencer
	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	// entry count clipped to the table depth
	function automatic logic [CNT_W-1:0] sat_count(input logic [CFG_W-1:0] cfg);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(cfg);
		if (wide > CMP_W'(TABLE_DEPTH)) begin
			return CNT_W'(TABLE_DEPTH);
		end
		return CNT_W'(wide);
	endfunction

endpackage

### rtl/core/stbs_ram.sv
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer: duplicate scan and binary search over the table memory, result
// register toward the output stream.
// ----------------------------------------------------------------------------
module stbs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [stbs_pkg::CNT_W-1:0]    count,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  stbs_pkg::op_t                 in_op,
	input  logic signed [stbs_pkg::WORD_W-1:0] in_key,
	input  logic [stbs_pkg::POS_W-1:0]    in_pos,
	output stbs_pkg::mem_req_t            mem_req,
	input  logic [stbs_pkg::WORD_W-1:0]   mem_rdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output stbs_pkg::status_t             out_status,
	output logic [stbs_pkg::POS_W-1:0]    out_index
);
	import stbs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SRCH,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic signed [WORD_W-1:0] key_q;
	logic [POS_W-1:0]         pos_q;
	logic [ADDR_W-1:0]        idx_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;      // exclusive upper bound
	status_t                  res_stat_q;
	logic [ADDR_W-1:0]        res_idx_q;
	logic                     out_valid_q;
	status_t                  out_stat_q;
	logic [POS_W-1:0]         out_idx_q;

	logic              accept;
	logic              hit;
	logic              less;
	logic              scan_last;
	logic              pos_fits;
	logic [CNT_W-1:0]  nlo;
	logic [CNT_W-1:0]  nhi;
	logic [CNT_W:0]    nsum;
	logic [ADDR_W-1:0] nmid;
	logic [CNT_W:0]    sum0;
	logic [ADDR_W-1:0] mid0;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign hit       = (mem_rdata == key_q);
	assign less      = $signed(mem_rdata) < key_q;
	assign scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == count;
	assign pos_fits  = CMP_W'(pos_q) < CMP_W'(count);

	// next search window after a probe that missed
	assign nlo  = less ? (CNT_W'(idx_q) + CNT_W'(1)) : lo_q;
	assign nhi  = less ? hi_q : CNT_W'(idx_q);
	assign nsum = {1'b0, nlo} + {1'b0, nhi} - (CNT_W + 1)'(1);
	assign nmid = ADDR_W'(nsum >> 1);
	assign sum0 = {1'b0, count} - (CNT_W + 1)'(1);
	assign mid0 = ADDR_W'(sum0 >> 1);

	always_comb begin
		mem_req       = '0;
		mem_req.waddr = ADDR_W'(pos_q);
		mem_req.wdata = key_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && count != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = (in_op == OP_WRITE) ? '0 : mid0;
				end
			end
			S_SCAN: begin
				if (!hit && !scan_last) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx_q + ADDR_W'(1);
				end
				if (!hit && scan_last && pos_fits) begin
					mem_req.we = 1'b1;
				end
			end
			S_SRCH: begin
				if (!hit && nlo < nhi) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = nmid;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			key_q       <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			res_stat_q  <= STAT_OK;
			res_idx_q   <= '0;
			out_stat_q  <= STAT_OK;
			out_idx_q   <= '0;
		end else begin
			// in S_DONE the result load below decides the output valid
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q     <= in_key;
						pos_q     <= in_pos;
						lo_q      <= '0;
						hi_q      <= count;
						res_idx_q <= '0;
						if (count == '0) begin
							res_stat_q <= (in_op == OP_WRITE) ? STAT_RANGE : STAT_NOT_FOUND;
							state_q    <= S_DONE;
						end else if (in_op == OP_WRITE) begin
							idx_q   <= '0;
							state_q <= S_SCAN;
						end else begin
							idx_q   <= mid0;
							state_q <= S_SRCH;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_stat_q <= STAT_DUPLICATE;
						res_idx_q  <= idx_q;
						state_q    <= S_DONE;
					end else if (scan_last) begin
						res_stat_q <= pos_fits ? STAT_OK : STAT_RANGE;
						state_q    <= S_DONE;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				S_SRCH: begin
					if (hit) begin
						res_stat_q <= STAT_OK;
						res_idx_q  <= idx_q;
						state_q    <= S_DONE;
					end else if (nlo < nhi) begin
						lo_q  <= nlo;
						hi_q  <= nhi;
						idx_q <= nmid;
					end else begin
						res_stat_q <= STAT_NOT_FOUND;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_stat_q  <= res_stat_q;
						out_idx_q   <= POS_W'(res_idx_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_stat_q;
	assign out_index  = out_idx_q;

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("table read and write in the same cycle");

	a_read_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.re |-> (CNT_W'(mem_req.raddr) < count))
		else $error("table read beyond entries in use");

	a_write_only_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |=> (state_q == S_DONE && res_stat_q == STAT_OK))
		else $error("table write without ok result");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted item left sequencer idle");

endmodule

### rtl/core/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed words with duplicate-checked writes and binary search.
// ----------------------------------------------------------------------------
// The table lives in one RAM with a single read port and registered read data,
// and every table read goes through that port one word a cycle.
// A write item scans the entries in use (clipped to the table depth) for a
// duplicate, reading one entry per step from entry 0 (the scan stops at the
// first equal entry), then loads the result into the output register.
// A search item reads one entry per probe of the binary search.
// An empty table answers without a table read. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
module sorted_table_binary_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stbs_pkg::CFG_W-1:0]    cfg_data,   // entries_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [39:0]                   s_tdata,    // key[31:0], position[37:32]
	input  logic                          s_tuser,    // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,    // found_index[5:0]
	output logic [1:0]                    m_tuser     // status
);
	import stbs_pkg::*;

	logic [CFG_W-1:0]  entries_q;
	logic [CNT_W-1:0]  count;
	mem_req_t          mem_req;
	logic [WORD_W-1:0] mem_rdata;
	status_t           out_status;
	logic [POS_W-1:0]  out_index;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entries_q <= cfg_data;
		end
	end

	assign count = sat_count(entries_q);

	stbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.count      (count),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (op_t'(s_tuser)),
		.in_key     ($signed(s_tdata[WORD_W-1:0])),
		.in_pos     (s_tdata[WORD_W+POS_W-1:WORD_W]),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_index  (out_index)
	);

	stbs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	assign m_tdata = {{(8 - POS_W){1'b0}}, out_index};
	assign m_tuser = out_status;

endmodule
